FILE: src/tcr_pkg.sv
// shared constants, types and helpers of the clock-replacement translation buffer
`timescale 1ns / 1ps
`default_nettype none

package tcr_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PAGE_W  = 20;
  localparam int REQ_W   = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_CLR_ENTRY = 3'd2,
    REQ_CLR_ALL   = 3'd3,
    REQ_CLR_REF   = 3'd4,
    REQ_WB_ALL    = 3'd5
  } req_e;

  // update strobes and operands towards the tag array
  typedef struct packed {
    logic              lookup;
    logic              insert;
    logic              clr_entry;
    logic              clr_all;
    logic              clr_ref;
    logic              store;
    logic              new_mod;
    logic              new_ref;
    logic [PAGE_W-1:0] page;
  } tag_cmd_t;

  // match, victim choice and per-entry bits from the tag array
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] modified;
    logic [ENTRIES-1:0] referenced;
  } tag_stat_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] lowest_idx(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: src/tcr_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface tcr_req_if
  import tcr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PAGE_W-1:0] virt_page;
  logic [PAGE_W-1:0] new_frame;
  logic              is_store;
  logic              new_modified;
  logic              new_referenced;

  modport source (
    output valid, req_type, virt_page, new_frame, is_store, new_modified, new_referenced,
    input  ready
  );
  modport sink (
    input  valid, req_type, virt_page, new_frame, is_store, new_modified, new_referenced,
    output ready
  );
endinterface

interface tcr_rsp_if
  import tcr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [PAGE_W-1:0] frame_out;
  logic              is_writeback;
  logic              wb_modified;
  logic              wb_referenced;
  logic              last;

  modport source (
    output valid, hit, frame_out, is_writeback, wb_modified, wb_referenced, last,
    input  ready
  );
  modport sink (
    input  valid, hit, frame_out, is_writeback, wb_modified, wb_referenced, last,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/tcr_ram.sv
// simple dual-port frame memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tcr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 20
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/tcr_tags.sv
// tag array: pages, status bits, parallel match and clock victim choice
`timescale 1ns / 1ps
`default_nettype none

module tcr_tags
  import tcr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tag_cmd_t  cmd_i,
  output tag_stat_t      stat_o
);

  logic [PAGE_W-1:0]  page_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] ref_q;
  logic [ENTRIES-1:0] mod_q;
  logic [IDX_W-1:0]   hand_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] cand;
  logic [ENTRIES-1:0] from_hand;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   victim;
  logic [IDX_W-1:0]   hand_next;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid_q[i] && (page_q[i] == cmd_i.page);
      from_hand[i] = (IDX_W'(i) >= hand_q);
    end
  end

  assign hit     = |match;
  assign hit_idx = lowest_idx(match);

  // invalid or unreferenced entries, searched from the hand with wrap
  assign cand = ~(valid_q & ref_q);

  always_comb begin
    if (|(cand & from_hand)) begin
      victim = lowest_idx(cand & from_hand);
    end else if (|cand) begin
      victim = lowest_idx(cand);
    end else begin
      victim = hand_q;
    end
  end

  assign hand_next = (victim == IDX_W'(ENTRIES - 1)) ? '0 : victim + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
      mod_q   <= '0;
      hand_q  <= '0;
    end else begin
      if (cmd_i.lookup && hit) begin
        ref_q[hit_idx] <= 1'b1;
        if (cmd_i.store) begin
          mod_q[hit_idx] <= 1'b1;
        end
      end
      if (cmd_i.insert) begin
        valid_q[victim] <= 1'b1;
        ref_q[victim]   <= cmd_i.new_ref;
        mod_q[victim]   <= cmd_i.new_mod;
        hand_q          <= hand_next;
      end
      if (cmd_i.clr_entry && hit) begin
        valid_q[hit_idx] <= 1'b0;
      end
      if (cmd_i.clr_all) begin
        valid_q <= '0;
      end
      if (cmd_i.clr_ref) begin
        ref_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      page_q[victim] <= cmd_i.page;
    end
  end

  assign stat_o.hit        = hit;
  assign stat_o.hit_idx    = hit_idx;
  assign stat_o.victim_idx = victim;
  assign stat_o.valid      = valid_q;
  assign stat_o.modified   = mod_q;
  assign stat_o.referenced = ref_q;

endmodule

`default_nettype wire

FILE: src/tlb_clock_replacement.sv
// top level: request sequencer, frame memory, tag array and response register
//
//   channel  dir  beat content
//   req_i    in   req_type, virt_page, new_frame, is_store, new_modified, new_referenced
//   rsp_o    out  hit, frame_out, is_writeback, wb_modified, wb_referenced, last
//
// clears act at the edge that accepts them; a lookup and an insert wait for the
// registered read of the frame memory; write back all reads the valid entries in
// turn. one request is in work at a time; a waiting response beat stalls the
// sequencer when it has a new beat to load, and so blocks the next request.
// reset empties tag array and hand at once; the frame memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module tlb_clock_replacement
  import tcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcr_req_if.sink   req_i,
  tcr_rsp_if.source rsp_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_INS  = 5'b00100,
    S_WB   = 5'b01000,
    S_WBO  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  tag_cmd_t           cmd;
  tag_stat_t          stat;
  logic               accept;
  logic               out_free;
  logic               load;

  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [PAGE_W-1:0]  ram_rdata;

  logic [IDX_W-1:0]   idx_q;
  logic [PAGE_W-1:0]  frame_q;
  logic               hit_q;
  logic               evict_q;
  logic               wbm_q;
  logic               wbr_q;
  logic               last_q;
  logic [ENTRIES-1:0] pend_q;
  logic [IDX_W-1:0]   wb_idx;
  logic [ENTRIES-1:0] pend_next;

  logic               rsp_valid_q;
  logic               hit_o_q;
  logic [PAGE_W-1:0]  frame_o_q;
  logic               wb_o_q;
  logic               wbm_o_q;
  logic               wbr_o_q;
  logic               last_o_q;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign wb_idx    = lowest_idx(pend_q);
  assign pend_next = pend_q & ~(ENTRIES'(1) << wb_idx);

  always_comb begin
    cmd           = '0;
    cmd.store     = req_i.is_store;
    cmd.new_mod   = req_i.new_modified;
    cmd.new_ref   = req_i.new_referenced;
    cmd.page      = req_i.virt_page;
    if (accept) begin
      unique case (req_i.req_type)
        REQ_LOOKUP:    cmd.lookup    = 1'b1;
        REQ_INSERT:    cmd.insert    = 1'b1;
        REQ_CLR_ENTRY: cmd.clr_entry = 1'b1;
        REQ_CLR_ALL:   cmd.clr_all   = 1'b1;
        REQ_CLR_REF:   cmd.clr_ref   = 1'b1;
        default: ;
      endcase
    end
  end

  tcr_tags u_tags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = stat.hit_idx;
    if (cmd.lookup) begin
      ram_re = 1'b1;
    end else if (cmd.insert) begin
      ram_re    = 1'b1;
      ram_raddr = stat.victim_idx;
    end else if (state_q == S_WB) begin
      ram_re    = 1'b1;
      ram_raddr = wb_idx;
    end
  end

  // the new frame goes in after the evicted one has been read
  tcr_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (PAGE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_INS),
    .waddr_i (idx_q),
    .wdata_i (frame_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd.lookup) begin
          state_d = S_LOOK;
        end else if (cmd.insert) begin
          state_d = S_INS;
        end else if (accept && (req_i.req_type == REQ_WB_ALL) && (|stat.valid)) begin
          state_d = S_WB;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS: begin
        if (!evict_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_WB: begin
        state_d = S_WBO;
      end
      S_WBO: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = last_q ? S_IDLE : S_WB;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i) begin
    if (cmd.lookup) begin
      hit_q <= stat.hit;
    end
    if (cmd.insert) begin
      idx_q   <= stat.victim_idx;
      frame_q <= req_i.new_frame;
      evict_q <= stat.valid[stat.victim_idx];
      wbm_q   <= stat.modified[stat.victim_idx];
      wbr_q   <= stat.referenced[stat.victim_idx];
    end
    if (accept && (req_i.req_type == REQ_WB_ALL)) begin
      pend_q <= stat.valid;
    end
    if (state_q == S_WB) begin
      pend_q <= pend_next;
      wbm_q  <= stat.modified[wb_idx];
      wbr_q  <= stat.referenced[wb_idx];
      last_q <= (pend_next == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (state_q == S_LOOK) begin
        hit_o_q   <= hit_q;
        frame_o_q <= hit_q ? ram_rdata : '0;
        wb_o_q    <= 1'b0;
        wbm_o_q   <= 1'b0;
        wbr_o_q   <= 1'b0;
        last_o_q  <= 1'b1;
      end else begin
        hit_o_q   <= 1'b0;
        frame_o_q <= ram_rdata;
        wb_o_q    <= 1'b1;
        wbm_o_q   <= wbm_q;
        wbr_o_q   <= wbr_q;
        last_o_q  <= (state_q == S_INS) ? 1'b1 : last_q;
      end
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = hit_o_q;
  assign rsp_o.frame_out     = frame_o_q;
  assign rsp_o.is_writeback  = wb_o_q;
  assign rsp_o.wb_modified   = wbm_o_q;
  assign rsp_o.wb_referenced = wbr_o_q;
  assign rsp_o.last          = last_o_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// regression bench for the clock-replacement translation buffer: random traffic against a predictor
`timescale 1ns / 1ps

module tb;
  import tcr_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_SPARE7 = 3'd7;
  localparam logic [PAGE_W-1:0] PAGE_MAX   = 20'hFFFFF;
  localparam int N_RANDOM   = 335;
  localparam int POOL_SIZE  = 24;
  localparam int HOLD_AT    = 250;
  localparam int HOLD_LEN   = 250;
  localparam int CALM_FROM  = 300;
  localparam int CALM_TO    = 360;
  localparam int IDLE_PCT   = 17;
  localparam int TAIL_WAIT  = 40;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
    logic              store;
    logic              nmod;
    logic              nref;
    logic              drain_first;
  } tlb_req_t;

  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] frame;
    logic              is_wb;
    logic              wb_mod;
    logic              wb_ref;
    logic              last;
  } rsp_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tcr_req_if req_if ();
  tcr_rsp_if rsp_if ();

  tlb_clock_replacement u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the translation buffer
  logic              tlb_valid [ENTRIES];
  logic [PAGE_W-1:0] tlb_page  [ENTRIES];
  logic [PAGE_W-1:0] tlb_frame [ENTRIES];
  logic              tlb_mod   [ENTRIES];
  logic              tlb_ref   [ENTRIES];
  int                tlb_hand;

  tlb_req_t          pending_reqs[$];
  rsp_beat_t         exp_beats[$];
  tlb_req_t          offer_req;
  logic [PAGE_W-1:0] page_pool[POOL_SIZE];

  int  n_total    = 0;
  int  n_accepted = 0;
  int  n_errors   = 0;
  int  n_beats    = 0;
  int  n_lookups  = 0;
  int  n_hits     = 0;
  int  n_inserts  = 0;
  int  n_evicts   = 0;
  int  n_wb_all   = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  bit  req_open;
  wire calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

  function automatic int lowest_match(input logic [PAGE_W-1:0] page);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tlb_valid[i] && tlb_page[i] == page) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void tlb_predict(input tlb_req_t rq);
    int        idx;
    int        last_idx;
    rsp_beat_t b;
    b = '0;
    case (rq.kind)
      REQ_LOOKUP: begin
        n_lookups++;
        idx = lowest_match(rq.page);
        if (idx >= 0) begin
          n_hits++;
          tlb_ref[idx] = 1'b1;
          if (rq.store) begin
            tlb_mod[idx] = 1'b1;
          end
          b.hit   = 1'b1;
          b.frame = tlb_frame[idx];
        end
        b.last = 1'b1;
        exp_beats.push_back(b);
      end
      REQ_INSERT: begin
        n_inserts++;
        idx = tlb_hand;
        for (int s = 0; s < ENTRIES; s++) begin
          if (!tlb_valid[idx] || !tlb_ref[idx]) begin
            break;
          end
          idx = (idx + 1) % ENTRIES;
        end
        // a fruitless sweep lands back on the hand
        if (tlb_valid[idx]) begin
          n_evicts++;
          b.frame  = tlb_frame[idx];
          b.is_wb  = 1'b1;
          b.wb_mod = tlb_mod[idx];
          b.wb_ref = tlb_ref[idx];
          b.last   = 1'b1;
          exp_beats.push_back(b);
        end
        tlb_valid[idx] = 1'b1;
        tlb_page[idx]  = rq.page;
        tlb_frame[idx] = rq.frame;
        tlb_mod[idx]   = rq.nmod;
        tlb_ref[idx]   = rq.nref;
        tlb_hand       = (idx + 1) % ENTRIES;
      end
      REQ_CLR_ENTRY: begin
        idx = lowest_match(rq.page);
        if (idx >= 0) begin
          tlb_valid[idx] = 1'b0;
        end
      end
      REQ_CLR_ALL: begin
        for (int i = 0; i < ENTRIES; i++) tlb_valid[i] = 1'b0;
      end
      REQ_CLR_REF: begin
        for (int i = 0; i < ENTRIES; i++) tlb_ref[i] = 1'b0;
      end
      REQ_WB_ALL: begin
        n_wb_all++;
        last_idx = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tlb_valid[i]) last_idx = i;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (tlb_valid[i]) begin
            b.frame  = tlb_frame[i];
            b.is_wb  = 1'b1;
            b.wb_mod = tlb_mod[i];
            b.wb_ref = tlb_ref[i];
            b.last   = (i == last_idx);
            exp_beats.push_back(b);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [PAGE_W-1:0] want,
                                      input logic [PAGE_W-1:0] got);
    if (want !== got) begin
      $error("response field %s: expected %h, actual %h", fname, want, got);
      n_errors++;
    end
  endfunction

  function automatic void add_req(input logic [REQ_W-1:0] kind, input logic [PAGE_W-1:0] page,
                                  input logic [PAGE_W-1:0] frame, input logic store,
                                  input logic nmod, input logic nref);
    tlb_req_t rq;
    rq.kind        = kind;
    rq.page        = page;
    rq.frame       = frame;
    rq.store       = store;
    rq.nmod        = nmod;
    rq.nref        = nref;
    rq.drain_first = 1'b0;
    pending_reqs.push_back(rq);
    n_total++;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(99) < 15) begin
      return PAGE_W'($urandom);
    end
    return page_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic logic [PAGE_W-1:0] rand_frame();
    return PAGE_W'($urandom);
  endfunction

  initial begin
    req_if.valid          = 1'b0;
    req_if.req_type       = REQ_LOOKUP;
    req_if.virt_page      = '0;
    req_if.new_frame      = '0;
    req_if.is_store       = 1'b0;
    req_if.new_modified   = 1'b0;
    req_if.new_referenced = 1'b0;
    rsp_if.ready          = 1'b0;
    tlb_hand              = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tlb_valid[i] = 1'b0;
      tlb_page[i]  = '0;
      tlb_frame[i] = '0;
      tlb_mod[i]   = 1'b0;
      tlb_ref[i]   = 1'b0;
    end
  end

  // request driver: offers the next pending item, predicts on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      req_open = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        tlb_predict(offer_req);
        n_accepted++;
        req_open = 1'b0;
      end
      if (!req_open) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain_first && exp_beats.size() != 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          offer_req = pending_reqs.pop_front();
          req_if.valid          <= 1'b1;
          req_if.req_type       <= offer_req.kind;
          req_if.virt_page      <= offer_req.page;
          req_if.new_frame      <= offer_req.frame;
          req_if.is_store       <= offer_req.store;
          req_if.new_modified   <= offer_req.nmod;
          req_if.new_referenced <= offer_req.nref;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: checks each beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        n_beats++;
        if (exp_beats.size() == 0) begin
          $error("response beat with nothing expected: frame_out %h", rsp_if.frame_out);
          n_errors++;
        end else begin
          rsp_beat_t want;
          want = exp_beats.pop_front();
          check_field("hit", PAGE_W'(want.hit), PAGE_W'(rsp_if.hit));
          check_field("frame_out", want.frame, rsp_if.frame_out);
          check_field("is_writeback", PAGE_W'(want.is_wb), PAGE_W'(rsp_if.is_writeback));
          check_field("wb_modified", PAGE_W'(want.wb_mod), PAGE_W'(rsp_if.wb_modified));
          check_field("wb_referenced", PAGE_W'(want.wb_ref), PAGE_W'(rsp_if.wb_referenced));
          check_field("last", PAGE_W'(want.last), PAGE_W'(rsp_if.last));
        end
      end
      // one long hold-off so the block backs up onto its request side
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int n_real;
    int r;
    logic [REQ_W-1:0] kind;

    page_pool[0] = '0;
    page_pool[1] = PAGE_MAX;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = PAGE_W'($urandom);

    // directed opening: empty buffer, extremes, duplicates, ignored codes
    add_req(REQ_LOOKUP,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_WB_ALL,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_CLR_ENTRY, PAGE_MAX, '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_SPARE6,    PAGE_MAX, PAGE_MAX, 1'b1, 1'b1, 1'b1);
    add_req(REQ_SPARE7,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_INSERT,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_INSERT,    PAGE_MAX, PAGE_MAX, 1'b0, 1'b1, 1'b1);
    add_req(REQ_LOOKUP,    '0,       '0,       1'b1, 1'b0, 1'b0);
    add_req(REQ_LOOKUP,    PAGE_MAX, '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_INSERT,    '0,       20'hABCDE, 1'b0, 1'b0, 1'b1);
    add_req(REQ_LOOKUP,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_CLR_ENTRY, '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_LOOKUP,    '0,       '0,       1'b1, 1'b0, 1'b0);
    add_req(REQ_WB_ALL,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_CLR_REF,   '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_INSERT,    20'h12345, 20'h54321, 1'b0, 1'b1, 1'b0);
    add_req(REQ_WB_ALL,    '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_CLR_ALL,   '0,       '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_LOOKUP,    PAGE_MAX, '0,       1'b0, 1'b0, 1'b0);
    add_req(REQ_WB_ALL,    '0,       '0,       1'b0, 1'b0, 1'b0);

    n_real = 0;
    while (n_real < N_RANDOM) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // fill with referenced entries until a full sweep forces the hand
        for (int k = 0; k <= ENTRIES; k++) begin
          add_req(REQ_INSERT, pick_page(), rand_frame(), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b1);
        end
        add_req(REQ_LOOKUP, pick_page(), rand_frame(), 1'($urandom_range(1)), 1'b0, 1'b0);
        add_req(REQ_WB_ALL, pick_page(), rand_frame(), 1'b0, 1'b0, 1'b0);
        n_real += ENTRIES + 3;
      end else if (r < 20) begin
        // noise: any code, any field
        for (int k = 0; k < 6; k++) begin
          kind = REQ_W'($urandom_range(7));
          add_req(kind, PAGE_W'($urandom), PAGE_W'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
          if (kind <= REQ_WB_ALL) n_real++;
        end
      end else begin
        for (int k = 0; k < 10; k++) begin
          r = $urandom_range(99);
          if (r < 45)      kind = REQ_LOOKUP;
          else if (r < 75) kind = REQ_INSERT;
          else if (r < 85) kind = REQ_CLR_ENTRY;
          else if (r < 90) kind = REQ_CLR_REF;
          else if (r < 94) kind = REQ_WB_ALL;
          else if (r < 96) kind = REQ_CLR_ALL;
          else if (r < 98) kind = REQ_SPARE6;
          else             kind = REQ_SPARE7;
          add_req(kind, pick_page(), rand_frame(), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
          if (kind <= REQ_WB_ALL) n_real++;
        end
      end
    end
    // sender waits for all expected responses to drain at these points
    pending_reqs[20].drain_first  = 1'b1;
    pending_reqs[180].drain_first = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total) @(posedge clk_i);
    while (exp_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("covered %0d requests: %0d lookups (%0d hits), %0d inserts (%0d evictions),",
             n_accepted, n_lookups, n_hits, n_inserts, n_evicts);
    $display("%0d write-back-all; checked %0d response beats, %0d mismatches",
             n_wb_all, n_beats, n_errors);
    if (n_errors == 0 && exp_beats.size() == 0) begin
      $display("tlb_clock_replacement regression: pass");
    end else begin
      $display("tlb_clock_replacement regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d beats outstanding", exp_beats.size());
    $display("tlb_clock_replacement regression: fail");
    $finish;
  end

endmodule
